@@ src/ray_box_slab_intersect_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the ray/box slab intersection block
// Concurrent checks in simulation, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`ifndef SYNTHESIS
`define RBSI_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("rbsi assertion failed");
`define RBSI_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("rbsi forbidden condition seen");
`else
`define RBSI_ASSERT(lbl, clk, rstn, prop)
`define RBSI_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ src/rbsi_pkg.sv @@
// ---------------------------------------------------------------------------
// rbsi_pkg
// Types and constants shared by the ray/box slab intersection block.
// ---------------------------------------------------------------------------
package rbsi_pkg;

	localparam int NUM_AXES  = 3;
	localparam int DIV_STEPS = 48;
	localparam int SIDE_LEN  = DIV_STEPS + 2;
	localparam int RBSI_LAT  = SIDE_LEN + 5;

	localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;
	localparam logic signed [63:0] PAR_EPS = 64'sd11;
	localparam logic signed [49:0] T_INF   = 50'sh1_0000_0000_0000;
	localparam logic signed [49:0] T_DMAX  = 50'sh0_0000_7FFF_FFFF;
	localparam logic [47:0]        T_SAT   = 48'h8000_0000_0000;

	localparam logic [63:0] RST_ROW0_A = 64'h0000_0000_0001_0000;
	localparam logic [63:0] RST_ROW0_B = 64'h0;
	localparam logic [63:0] RST_ROW1_A = 64'h0001_0000_0000_0000;
	localparam logic [63:0] RST_ROW1_B = 64'h0;
	localparam logic [63:0] RST_ROW2_A = 64'h0;
	localparam logic [63:0] RST_ROW2_B = 64'h0000_0000_0001_0000;

	typedef enum logic [2:0] {
		REG_ROW0_A,
		REG_ROW0_B,
		REG_ROW1_A,
		REG_ROW1_B,
		REG_ROW2_A,
		REG_ROW2_B
	} rbsi_reg_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] den;
		logic [47:0] qsh;
		logic        sat;
		logic        neg;
	} rbsi_div_t;

	typedef struct packed {
		logic par;
		logic inr;
		logic dneg;
	} rbsi_axis_t;

endpackage

@@ src/rbsi_cell.sv @@
// ---------------------------------------------------------------------------
// rbsi_cell
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ---------------------------------------------------------------------------
module rbsi_cell import rbsi_pkg::*; (
	input  logic      clk,
	input  rbsi_div_t d_in,
	output rbsi_div_t d_out
);

	logic [63:0] r;
	logic        ge;
	rbsi_div_t   nxt;
	rbsi_div_t   d_q;

	always_comb begin
		r = {d_in.rem[62:0], d_in.qsh[47]};
		ge = (r >= d_in.den);
		nxt = d_in;
		nxt.rem = ge ? (r - d_in.den) : r;
		nxt.qsh = {d_in.qsh[46:0], ge};
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign d_out = d_q;

endmodule

@@ src/rbsi_div.sv @@
// ---------------------------------------------------------------------------
// rbsi_div
// Signed Q32.16 quotient lane: prepare, chain of division cells, saturate.
// ---------------------------------------------------------------------------
module rbsi_div import rbsi_pkg::*; (
	input  logic               clk,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output logic signed [48:0] t
);

	logic [63:0] n_abs;
	logic [63:0] d_abs;
	rbsi_div_t   prep_s1;
	rbsi_div_t   stg [DIV_STEPS+1];
	logic [47:0] mag;
	logic signed [48:0] t_q;

	always_comb begin
		n_abs = num[63] ? 64'(-num) : 64'(num);
		d_abs = den[63] ? 64'(-den) : 64'(den);
	end

	always_ff @(posedge clk) begin
		prep_s1.rem <= {32'b0, n_abs[63:32]};
		prep_s1.den <= d_abs;
		prep_s1.qsh <= {n_abs[31:0], 16'b0};
		prep_s1.sat <= ({32'b0, n_abs[63:32]} >= d_abs);
		prep_s1.neg <= num[63] ^ den[63];
	end

	assign stg[0] = prep_s1;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
		rbsi_cell u_cell (
			.clk   (clk),
			.d_in  (stg[k]),
			.d_out (stg[k+1])
		);
	end

	assign mag = (stg[DIV_STEPS].sat || stg[DIV_STEPS].qsh[47]) ? T_SAT
		: stg[DIV_STEPS].qsh;

	always_ff @(posedge clk) begin
		t_q <= stg[DIV_STEPS].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	assign t = t_q;

endmodule

@@ src/ray_box_slab_intersect.sv @@
// ---------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against an affine-mapped unit cube, slab test, one ray per cycle.
// ---------------------------------------------------------------------------
// channel   | ports                                   | handshake
// ray in    | origin_x/y/z, dir_x/y/z                 | start, busy (always low)
// result    | hit, distance                           | done, one cycle
// config    | psel penable pwrite paddr pwdata prdata | pready always high
//
// A ray is taken every cycle and passes transform, divide and compare stages.
// The latency is set by the 48-cell division chain in each of six lanes.
// Reset clears the matrix to identity and drops every ray in flight.
// The result is shown for one cycle and cannot be held off.
// ---------------------------------------------------------------------------
`include "ray_box_slab_intersect_assert.svh"

module ray_box_slab_intersect import rbsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	output logic               done,
	output logic               hit,
	output logic [30:0]        distance,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	logic [63:0] cfg_q [6];
	rbsi_reg_t   reg_idx;
	logic        cfg_wr;

	logic signed [31:0] mat [NUM_AXES][NUM_AXES];
	logic signed [31:0] tr  [NUM_AXES];
	logic signed [31:0] ov  [NUM_AXES];
	logic signed [31:0] dv  [NUM_AXES];
	logic signed [63:0] po  [NUM_AXES][NUM_AXES];
	logic signed [63:0] pd  [NUM_AXES][NUM_AXES];

	logic signed [63:0] fo_s1 [NUM_AXES][NUM_AXES];
	logic signed [63:0] fd_s1 [NUM_AXES][NUM_AXES];
	logic signed [63:0] tr_s1 [NUM_AXES];
	logic signed [63:0] lo_s2 [NUM_AXES];
	logic signed [63:0] ld_s2 [NUM_AXES];
	logic signed [63:0] num0_s3 [NUM_AXES];
	logic signed [63:0] num1_s3 [NUM_AXES];
	logic signed [63:0] den_s3  [NUM_AXES];
	rbsi_axis_t [NUM_AXES-1:0] side_s3;
	rbsi_axis_t [NUM_AXES-1:0] side_q [SIDE_LEN];
	logic vld_s1, vld_s2, vld_s3;
	logic [SIDE_LEN-1:0] vld_q;

	logic signed [48:0] t0 [NUM_AXES];
	logic signed [48:0] t1 [NUM_AXES];

	logic signed [49:0] te, tx, tmin_c, tmax_c;
	logic               miss_c;
	logic signed [49:0] tmin_s5, tmax_s5;
	logic               miss_s5, vld_s5;

	logic signed [49:0] t_sel;
	logic               miss_f;
	logic               done_q, hit_q;
	logic [30:0]        dist_q;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign reg_idx = rbsi_reg_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= RST_ROW0_A;
			cfg_q[1] <= RST_ROW0_B;
			cfg_q[2] <= RST_ROW1_A;
			cfg_q[3] <= RST_ROW1_B;
			cfg_q[4] <= RST_ROW2_A;
			cfg_q[5] <= RST_ROW2_B;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ROW0_A: cfg_q[0] <= pwdata;
				REG_ROW0_B: cfg_q[1] <= pwdata;
				REG_ROW1_A: cfg_q[2] <= pwdata;
				REG_ROW1_B: cfg_q[3] <= pwdata;
				REG_ROW2_A: cfg_q[4] <= pwdata;
				REG_ROW2_B: cfg_q[5] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ROW0_A: prdata = cfg_q[0];
			REG_ROW0_B: prdata = cfg_q[1];
			REG_ROW1_A: prdata = cfg_q[2];
			REG_ROW1_B: prdata = cfg_q[3];
			REG_ROW2_A: prdata = cfg_q[4];
			REG_ROW2_B: prdata = cfg_q[5];
			default:    prdata = 64'h0;
		endcase
	end

	always_comb begin
		ov[0] = origin_x;
		ov[1] = origin_y;
		ov[2] = origin_z;
		dv[0] = dir_x;
		dv[1] = dir_y;
		dv[2] = dir_z;
		for (int r = 0; r < NUM_AXES; r++) begin
			mat[r][0] = cfg_q[2*r][31:0];
			mat[r][1] = cfg_q[2*r][63:32];
			mat[r][2] = cfg_q[2*r+1][31:0];
			tr[r]     = cfg_q[2*r+1][63:32];
			for (int c = 0; c < NUM_AXES; c++) begin
				po[r][c] = mat[r][c] * ov[c];
				pd[r][c] = mat[r][c] * dv[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_AXES; r++) begin
			for (int c = 0; c < NUM_AXES; c++) begin
				fo_s1[r][c] <= po[r][c] >>> 2;
				fd_s1[r][c] <= pd[r][c] >>> 2;
			end
			tr_s1[r] <= {{18{tr[r][31]}}, tr[r], 14'b0};
			lo_s2[r] <= fo_s1[r][0] + fo_s1[r][1] + fo_s1[r][2] + tr_s1[r];
			ld_s2[r] <= fd_s1[r][0] + fd_s1[r][1] + fd_s1[r][2];
			num0_s3[r] <= -ONE_Q30 - lo_s2[r];
			num1_s3[r] <= ONE_Q30 - lo_s2[r];
			den_s3[r]  <= ld_s2[r];
			side_s3[r].par  <= (ld_s2[r] > -PAR_EPS) && (ld_s2[r] < PAR_EPS);
			side_s3[r].inr  <= !((lo_s2[r] < -ONE_Q30) || (lo_s2[r] > ONE_Q30));
			side_s3[r].dneg <= ld_s2[r][63];
		end
		side_q[0] <= side_s3;
		for (int k = 1; k < SIDE_LEN; k++) begin
			side_q[k] <= side_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= '0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= {vld_q[SIDE_LEN-2:0], vld_s3};
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		rbsi_div u_div_lo (
			.clk (clk),
			.num (num0_s3[a]),
			.den (den_s3[a]),
			.t   (t0[a])
		);
		rbsi_div u_div_hi (
			.clk (clk),
			.num (num1_s3[a]),
			.den (den_s3[a]),
			.t   (t1[a])
		);
	end

	always_comb begin
		tmin_c = -T_INF;
		tmax_c = T_INF;
		miss_c = 1'b0;
		te = '0;
		tx = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (side_q[SIDE_LEN-1][a].par) begin
				if (!side_q[SIDE_LEN-1][a].inr) begin
					miss_c = 1'b1;
				end
			end else begin
				te = side_q[SIDE_LEN-1][a].dneg ? 50'(t1[a]) : 50'(t0[a]);
				tx = side_q[SIDE_LEN-1][a].dneg ? 50'(t0[a]) : 50'(t1[a]);
				if (te > tmin_c) begin
					tmin_c = te;
				end
				if (tx < tmax_c) begin
					tmax_c = tx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		tmin_s5 <= tmin_c;
		tmax_s5 <= tmax_c;
		miss_s5 <= miss_c;
	end

	always_comb begin
		miss_f = miss_s5 || (tmax_s5 < tmin_s5) || (tmax_s5 < 50'sd0);
		t_sel  = (tmin_s5 >= 50'sd0) ? tmin_s5 : tmax_s5;
	end

	always_ff @(posedge clk) begin
		hit_q  <= !miss_f;
		dist_q <= miss_f ? 31'h0 : ((t_sel > T_DMAX) ? 31'h7FFF_FFFF : t_sel[30:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s5 <= vld_q[SIDE_LEN-1];
			done_q <= vld_s5;
		end
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign distance = dist_q;

	`RBSI_ASSERT(a_miss_zero, clk, arst_n, (done && !hit) |-> (distance == 31'h0))
	`RBSI_ASSERT(a_latency, clk, arst_n, (start && !busy) |-> ##RBSI_LAT done)
	`RBSI_NEVER(a_never_busy, clk, arst_n, busy)

endmodule

@@ tb/ray_box_slab_checker.sv @@
// ---------------------------------------------------------------------------
// Ray/box slab intersection checker
// Mirrors the inverse matrix from APB writes, predicts hit and distance for
// every accepted ray, and compares each result strobe against the oldest one.
// ---------------------------------------------------------------------------
module ray_box_slab_checker import rbsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic               done,
	input  logic               hit,
	input  logic [30:0]        distance,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
	} slab_hit_t;

	logic [63:0] inv_mat [6];
	slab_hit_t   hit_q [$];

	function automatic longint word_lo(input logic [63:0] w);
		return longint'(signed'(w[31:0]));
	endfunction

	function automatic longint word_hi(input logic [63:0] w);
		return longint'(signed'(w[63:32]));
	endfunction

	function automatic longint quot_q16(input longint num, input longint den);
		logic [63:0] n, d, r, mag;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		r = n % d;
		mag = n / d;
		if (mag >= 64'h8000_0000) begin
			mag = 64'h8000_0000_0000;
		end else begin
			for (int i = 0; i < 16; i++) begin
				r = r << 1;
				mag = mag << 1;
				if (r >= d) begin
					r = r - d;
					mag[0] = 1'b1;
				end
			end
		end
		return ((num < 0) != (den < 0)) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic slab_hit_t trace_ray(input longint o[3], input longint d[3]);
		longint lo [3];
		longint ld [3];
		longint tmin, tmax, t0, t1, sw, t;
		longint one;
		logic   miss;
		slab_hit_t res;
		one = longint'(ONE_Q30);
		tmin = -(longint'(1) << 62);
		tmax = longint'(1) << 62;
		miss = 1'b0;
		for (int i = 0; i < 3; i++) begin
			lo[i] = ((word_lo(inv_mat[2*i]) * o[0]) >>> 2)
				+ ((word_hi(inv_mat[2*i]) * o[1]) >>> 2)
				+ ((word_lo(inv_mat[2*i+1]) * o[2]) >>> 2)
				+ word_hi(inv_mat[2*i+1]) * 16384;
			ld[i] = ((word_lo(inv_mat[2*i]) * d[0]) >>> 2)
				+ ((word_hi(inv_mat[2*i]) * d[1]) >>> 2)
				+ ((word_lo(inv_mat[2*i+1]) * d[2]) >>> 2);
		end
		for (int i = 0; i < 3; i++) begin
			if (!miss) begin
				if (ld[i] > -longint'(PAR_EPS) && ld[i] < longint'(PAR_EPS)) begin
					if (lo[i] < -one || lo[i] > one)
						miss = 1'b1;
				end else begin
					t0 = quot_q16(-one - lo[i], ld[i]);
					t1 = quot_q16(one - lo[i], ld[i]);
					if (ld[i] < 0) begin
						sw = t0;
						t0 = t1;
						t1 = sw;
					end
					if (t0 > tmin) tmin = t0;
					if (t1 < tmax) tmax = t1;
					if (tmax < tmin) miss = 1'b1;
				end
			end
		end
		if (!miss && tmax < 0)
			miss = 1'b1;
		if (miss) begin
			res = '0;
		end else begin
			t = tmin >= 0 ? tmin : tmax;
			res.hit = 1'b1;
			res.distance = (t > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : t[30:0];
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		longint o [3];
		longint d [3];
		slab_hit_t want;
		logic bad;
		if (!arst_n) begin
			inv_mat[REG_ROW0_A] <= RST_ROW0_A;
			inv_mat[REG_ROW0_B] <= RST_ROW0_B;
			inv_mat[REG_ROW1_A] <= RST_ROW1_A;
			inv_mat[REG_ROW1_B] <= RST_ROW1_B;
			inv_mat[REG_ROW2_A] <= RST_ROW2_A;
			inv_mat[REG_ROW2_B] <= RST_ROW2_B;
			hit_q.delete();
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[5:3] <= REG_ROW2_B)
				inv_mat[paddr[5:3]] <= pwdata;
			if (start && !busy) begin
				o[0] = origin_x; o[1] = origin_y; o[2] = origin_z;
				d[0] = dir_x;    d[1] = dir_y;    d[2] = dir_z;
				hit_q.push_back(trace_ray(o, d));
			end
			if (done) begin
				if (hit_q.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = hit_q.pop_front();
					bad = 1'b0;
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						bad = 1'b1;
					end
					if (distance !== want.distance) begin
						$error("distance: expected %h, got %h", want.distance, distance);
						bad = 1'b1;
					end
					if (bad)
						fail_count <= fail_count + 1;
				end
			end
		end
	end

	assign pending = hit_q.size();

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// Ray/box slab intersection testbench
// Loads several inverse matrices over APB, identity, scaled, random and
// extreme among them, and streams directed and random rays with random gaps;
// the checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
	import rbsi_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam int         WDOG_LIMIT = 4000;
	localparam logic [31:0] Q_ONE     = 32'h0001_0000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] origin_x, origin_y, origin_z;
	logic signed [31:0] dir_x, dir_y, dir_z;
	logic               done;
	logic               hit;
	logic [30:0]        distance;
	logic               psel, penable, pwrite;
	logic [5:0]         paddr;
	logic [63:0]        pwdata;
	logic [63:0]        prdata;
	logic               pready;
	int                 fail_count;
	int                 pending;
	int                 idle_cycles;

	ray_box_slab_intersect u_dut (.*);

	ray_box_slab_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stop sending and wait until every transaction in flight has completed
	task automatic drain;
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (RBSI_LAT + 5) @(posedge clk);
	endtask

	task automatic load_matrix(input logic [63:0] m [6]);
		drain();
		for (int i = 0; i < 6; i++)
			reg_write(3'(i), m[i]);
	endtask

	// drive one ray, hold it until accepted, then insert a random gap, which may be zero
	task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
		int gap;
		start <= 1'b1;
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		gap = $urandom_range(0, 9) < 6 ? 0 :
			($urandom_range(0, 19) == 0 ? $urandom_range(20, 90) : $urandom_range(1, 4));
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] near_q(input int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_rays(input int count);
		logic [31:0] o [3];
		logic [31:0] tg [3];
		int sh;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 7) begin
				sh = $urandom_range(0, 4);
				for (int a = 0; a < 3; a++) begin
					o[a] = near_q(4 * 65536);
					tg[a] = near_q(65536);
					tg[a] = $signed(tg[a] - o[a]) >>> sh;
				end
				if ($urandom_range(0, 7) == 0)
					tg[$urandom_range(0, 2)] = 32'h0;
				send_ray(o[0], o[1], o[2], tg[0], tg[1], tg[2]);
			end else begin
				send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		logic [63:0] m [6];
		arst_n = 1'b0;
		start = 1'b0;
		origin_x = '0; origin_y = '0; origin_z = '0;
		dir_x = '0; dir_y = '0; dir_z = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix after reset
		send_ray(32'hFFFD_0000, 0, 0, Q_ONE, 0, 0);
		send_ray(32'h0003_0000, 0, 0, Q_ONE, 0, 0);
		send_ray(0, 0, 0, 0, 0, 0);
		send_ray(0, 0, 0, 0, Q_ONE, 0);
		send_ray(32'h0000_8000, 32'hFFFF_8000, 0, 0, 0, 32'hFFFF_0000);
		send_ray(32'h0002_0000, 0, 0, 0, Q_ONE, 0);
		send_ray(0, 32'hFFFE_0000, 0, 0, 0, Q_ONE);
		send_ray(32'h0002_0000, 32'h0002_0000, 0, 32'hFFFF_0000, 0, 0);
		send_ray(32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 0);
		send_ray(32'h8000_0000, 0, 0, 32'h0000_0001, 0, 0);
		send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_ray(32'hFFFE_0000, 0, 0, 32'h0000_0001, 0, 0);
		send_ray(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, Q_ONE, Q_ONE, Q_ONE);
		send_ray(32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000, Q_ONE, Q_ONE, Q_ONE);
		send_ray(32'h0001_0001, 0, 0, 0, 0, Q_ONE);
		send_ray(0, 0, 0, 32'h0000_000A, 32'hFFFF_FFF6, 0);
		send_ray(0, 0, 0, 32'h0000_000B, 0, 0);
		random_rays(60);

		// axis scales and translations
		for (int r = 0; r < 3; r++) begin
			m[2*r] = 64'h0;
			m[2*r][32*(r%2) +: 32] = $urandom_range(32'h4000, 32'h40000);
			m[2*r+1] = {near_q(2 * 65536), 32'h0};
		end
		m[REG_ROW2_B][31:0] = $urandom_range(32'h4000, 32'h40000);
		m[REG_ROW2_A] = 64'h0;
		load_matrix(m);
		random_rays(80);

		// general random matrix
		foreach (m[i]) m[i] = {near_q(2 * 65536), near_q(2 * 65536)};
		load_matrix(m);
		random_rays(80);

		// extreme words
		m[REG_ROW0_A] = 64'h7FFF_FFFF_8000_0000;
		m[REG_ROW0_B] = 64'h8000_0000_7FFF_FFFF;
		m[REG_ROW1_A] = 64'hFFFF_FFFF_FFFF_FFFF;
		m[REG_ROW1_B] = 64'h7FFF_FFFF_8000_0000;
		m[REG_ROW2_A] = 64'h8000_0000_8000_0000;
		m[REG_ROW2_B] = 64'h7FFF_FFFF_7FFF_FFFF;
		load_matrix(m);
		random_rays(60);

		// zero matrix: every axis parallel, origin set by translation alone
		foreach (m[i]) m[i] = 64'h0;
		m[REG_ROW0_B] = {near_q(65536), 32'h0};
		load_matrix(m);
		reg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		random_rays(40);
		m[REG_ROW1_B] = 64'h0003_0000_0000_0000;
		load_matrix(m);
		random_rays(30);

		// back to identity with a small offset
		m[REG_ROW0_A] = RST_ROW0_A;
		m[REG_ROW0_B] = {near_q(65536), 32'h0};
		m[REG_ROW1_A] = RST_ROW1_A;
		m[REG_ROW1_B] = 64'h0;
		m[REG_ROW2_A] = RST_ROW2_A;
		m[REG_ROW2_B] = RST_ROW2_B;
		load_matrix(m);
		random_rays(100);

		start <= 1'b0;
		drain();
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/rbsi_pkg.sv
src/rbsi_cell.sv
src/rbsi_div.sv
src/ray_box_slab_intersect.sv
tb/ray_box_slab_checker.sv
tb/tb_top.sv
